// ----- sv/lcfa_pkg.sv -----
// ----------------------------------------------------------------------------
// lcfa_pkg
// Shared types and codes of the load-cell force alarm block.
// ----------------------------------------------------------------------------
package lcfa_pkg;

	localparam int ADDR_W = 5;
	localparam int DIFF_W = 25;
	localparam int QUO_W  = 26;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_PERIOD = 3'd1;
	localparam logic [2:0] REG_LIMIT  = 3'd2;
	localparam logic [2:0] REG_OFFSET = 3'd3;
	localparam logic [2:0] REG_SCALE  = 3'd4;

	localparam logic [1:0] MODE_POLL  = 2'd0;
	localparam logic [1:0] MODE_FORCE = 2'd1;
	localparam logic [1:0] MODE_RAW   = 2'd2;

	localparam logic [2:0] KIND_FORCE     = 3'd0;
	localparam logic [2:0] KIND_RAW       = 3'd1;
	localparam logic [2:0] KIND_ALARM     = 3'd2;
	localparam logic [2:0] KIND_NORMAL    = 3'd3;
	localparam logic [2:0] KIND_ALARM_VAL = 3'd4;
	localparam logic [2:0] KIND_NOT_READY = 3'd5;

	// Job codes handed from the front end to the back end.
	localparam logic [2:0] OP_PUB    = 3'd0;
	localparam logic [2:0] OP_WATCH  = 3'd1;
	localparam logic [2:0] OP_READF  = 3'd2;
	localparam logic [2:0] OP_RAW    = 3'd3;
	localparam logic [2:0] OP_NREADY = 3'd4;

	typedef struct packed {
		logic               enable;
		logic [31:0]        period_ms;
		logic signed [15:0] alarm_limit;
		logic signed [23:0] zero_offset;
		logic signed [31:0] scale_divisor;
	} cfg_t;

	typedef struct packed {
		logic [2:0]              op;
		logic signed [DIFF_W-1:0] data;
	} job_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value;
		logic               last;
	} res_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] dividend;
		logic signed [31:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- sv/lcfa_regs.sv -----
// ----------------------------------------------------------------------------
// lcfa_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module lcfa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcfa_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output lcfa_pkg::cfg_t                cfg
);
	import lcfa_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ENABLE: cfg_q.enable        <= pwdata[0];
				REG_PERIOD: cfg_q.period_ms     <= pwdata;
				REG_LIMIT:  cfg_q.alarm_limit   <= pwdata[15:0];
				REG_OFFSET: cfg_q.zero_offset   <= pwdata[23:0];
				REG_SCALE:  cfg_q.scale_divisor <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ENABLE: prdata = {31'd0, cfg_q.enable};
			REG_PERIOD: prdata = cfg_q.period_ms;
			REG_LIMIT:  prdata = {{16{cfg_q.alarm_limit[15]}}, cfg_q.alarm_limit};
			REG_OFFSET: prdata = {{8{cfg_q.zero_offset[23]}}, cfg_q.zero_offset};
			REG_SCALE:  prdata = cfg_q.scale_divisor;
			default:    prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/lcfa_front.sv -----
// ----------------------------------------------------------------------------
// lcfa_front
// Accepts input words, applies the enable and period rules and turns each
// word into at most one job for the back end.
// ----------------------------------------------------------------------------
module lcfa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          mode,
	input  logic [31:0]         time_ms,
	input  logic signed [23:0]  sample,
	input  logic                sample_ready,
	input  lcfa_pkg::cfg_t      cfg,
	input  logic                jobq_full,
	output logic                job_push,
	output lcfa_pkg::job_t      job
);
	import lcfa_pkg::*;

	logic [31:0]        last_emit_q;
	logic               accept;
	logic               want_job;
	logic               upd_time;
	logic               elapsed;
	logic [31:0]        delta;
	logic [DIFF_W-1:0]  diff;

	assign full     = jobq_full;
	assign accept   = push & ~jobq_full;
	assign delta    = time_ms - last_emit_q;
	assign elapsed  = (delta >= cfg.period_ms);
	assign diff     = {sample[23], sample} - {cfg.zero_offset[23], cfg.zero_offset};
	assign job_push = accept & want_job;

	always_comb begin
		want_job = 1'b0;
		upd_time = 1'b0;
		job.op   = OP_READF;
		job.data = diff;
		if (mode == MODE_POLL) begin
			if (cfg.enable) begin
				if (cfg.period_ms == 32'd0) begin
					want_job = sample_ready;
					job.op   = OP_WATCH;
				end else if (elapsed) begin
					// The time is stored even when the sample is not ready.
					upd_time = 1'b1;
					want_job = sample_ready;
					job.op   = OP_PUB;
				end
			end
		end else if (!sample_ready) begin
			want_job = 1'b1;
			job.op   = OP_NREADY;
		end else if (mode == MODE_RAW) begin
			want_job = 1'b1;
			job.op   = OP_RAW;
			job.data = {sample[23], sample};
		end else begin
			want_job = 1'b1;
			job.op   = OP_READF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_emit_q <= 32'd0;
		end else if (accept && upd_time) begin
			last_emit_q <= time_ms;
		end
	end

endmodule

// ----- sv/lcfa_jobq.sv -----
// ----------------------------------------------------------------------------
// lcfa_jobq
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lcfa_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lcfa_pkg::job_t  job_in,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output lcfa_pkg::job_t  job_out
);
	import lcfa_pkg::*;

	job_t       mem_q [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign job_out = mem_q[rd_q];
	assign do_wr   = push & ~full;
	assign do_rd   = pop & valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_q <= ~wr_q;
			end
			if (do_rd) begin
				rd_q <= ~rd_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/lcfa_div.sv -----
// ----------------------------------------------------------------------------
// lcfa_div
// Signed divider, one quotient bit per cycle, truncating toward zero.
// A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module lcfa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lcfa_pkg::div_req_t  req,
	output lcfa_pkg::div_rsp_t  rsp
);
	import lcfa_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'(DIFF_W - 1);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic              neg_q;
	logic [4:0]        cnt_q;
	logic [31:0]       rem_q;
	logic [31:0]       dmag_q;
	logic [DIFF_W-1:0] acc_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DIFF_W-1:0] amag;
	logic [31:0]       dmag;
	logic [32:0]       trial;
	logic [32:0]       trial_sub;
	logic              ge;

	assign amag      = req.dividend[DIFF_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign dmag      = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
	assign trial     = {rem_q, acc_q[DIFF_W-1]};
	assign trial_sub = trial - {1'b0, dmag_q};
	assign ge        = (trial >= {1'b0, dmag_q});

	assign rsp.busy     = busy_q | fin_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.divisor == 32'sd0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= LAST_STEP;
				end
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= 32'd0;
			acc_q  <= amag;
			dmag_q <= dmag;
			neg_q  <= req.dividend[DIFF_W-1] ^ req.divisor[31];
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[31:0] : trial[31:0];
			acc_q <= {acc_q[DIFF_W-2:0], ge};
		end else if (fin_q) begin
			quo_q <= neg_q ? (QUO_W'(0) - {1'b0, acc_q}) : {1'b0, acc_q};
		end
	end

endmodule

// ----- sv/lcfa_back.sv -----
// ----------------------------------------------------------------------------
// lcfa_back
// Carries out jobs: runs the divider, updates the alarm state and writes the
// result words into a four-entry output queue.
// ----------------------------------------------------------------------------
module lcfa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lcfa_pkg::cfg_t      cfg,
	input  logic                job_valid,
	input  lcfa_pkg::job_t      job,
	output logic                job_pop,
	output lcfa_pkg::div_req_t  div_req,
	input  lcfa_pkg::div_rsp_t  div_rsp,
	input  logic                pop,
	output logic                empty,
	output logic [2:0]          kind,
	output logic signed [31:0]  value,
	output logic                last
);
	import lcfa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [2:0] op_q;
	logic       alarm_on_q;
	res_t       word_q [0:2];

	res_t       fifo_q [0:3];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       fifo_wr;
	logic       fifo_rd;

	logic              needs_div;
	logic              has_force;
	logic              alarm_op;
	logic              over;
	logic              enter;
	logic              leave;
	logic              any_word;
	logic signed [31:0] f32;
	logic signed [26:0] f27;
	logic signed [26:0] lim27;
	logic signed [26:0] nlim27;
	res_t              nw [0:2];
	res_t              direct_word;

	// A job starts only when the output queue can take three words.
	assign job_pop   = (state_q == ST_IDLE) & job_valid & (cnt_q <= 3'd1);
	assign needs_div = job.op inside {OP_PUB, OP_WATCH, OP_READF};

	assign div_req.start    = job_pop & needs_div;
	assign div_req.dividend = job.data;
	assign div_req.divisor  = cfg.scale_divisor;

	assign has_force = op_q inside {OP_PUB, OP_READF};
	assign alarm_op  = op_q inside {OP_PUB, OP_WATCH};
	assign f32       = {{(32-QUO_W){div_rsp.quotient[QUO_W-1]}}, div_rsp.quotient};
	assign f27       = {div_rsp.quotient[QUO_W-1], div_rsp.quotient};
	assign lim27     = {{11{cfg.alarm_limit[15]}}, cfg.alarm_limit};
	assign nlim27    = -lim27;
	assign over      = (f27 > lim27) || (f27 < nlim27);
	assign enter     = alarm_op & over & ~alarm_on_q;
	assign leave     = alarm_op & ~over & alarm_on_q;
	assign any_word  = has_force | enter | leave;

	always_comb begin
		res_t w_alarm;
		res_t w_val;
		w_alarm.kind  = enter ? KIND_ALARM : KIND_NORMAL;
		w_alarm.value = 32'sd0;
		w_alarm.last  = 1'b0;
		w_val.kind    = KIND_ALARM_VAL;
		w_val.value   = enter ? f32 : 32'sd0;
		w_val.last    = 1'b1;
		nw[0] = '0;
		nw[1] = '0;
		nw[2] = '0;
		if (has_force) begin
			nw[0].kind  = KIND_FORCE;
			nw[0].value = f32;
			nw[0].last  = ~(enter | leave);
			nw[1]       = w_alarm;
			nw[2]       = w_val;
		end else begin
			nw[0] = w_alarm;
			nw[1] = w_val;
		end
	end

	always_comb begin
		direct_word.last = 1'b1;
		if (job.op == OP_RAW) begin
			direct_word.kind  = KIND_RAW;
			direct_word.value = {{(32-DIFF_W){job.data[DIFF_W-1]}}, job.data};
		end else begin
			direct_word.kind  = KIND_NOT_READY;
			direct_word.value = 32'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_READF;
			alarm_on_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						op_q    <= job.op;
						state_q <= needs_div ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (enter) begin
							alarm_on_q <= 1'b1;
						end else if (leave) begin
							alarm_on_q <= 1'b0;
						end
						state_q <= any_word ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (word_q[0].last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pending words shift toward slot zero, one word written per cycle.
	always_ff @(posedge clk) begin
		if (job_pop && !needs_div) begin
			word_q[0] <= direct_word;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			word_q[0] <= nw[0];
			word_q[1] <= nw[1];
			word_q[2] <= nw[2];
		end else if (state_q == ST_EMIT) begin
			word_q[0] <= word_q[1];
			word_q[1] <= word_q[2];
		end
	end

	assign fifo_wr = (state_q == ST_EMIT);
	assign fifo_rd = pop & ~empty;
	assign empty   = (cnt_q == 3'd0);
	assign kind    = fifo_q[rd_q].kind;
	assign value   = fifo_q[rd_q].value;
	assign last    = fifo_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (fifo_wr) begin
			fifo_q[wr_q] <= word_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (fifo_wr) begin
				wr_q <= wr_q + 2'd1;
			end
			if (fifo_rd) begin
				rd_q <= rd_q + 2'd1;
			end
			case ({fifo_wr, fifo_rd})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/load_cell_force_alarm.sv -----
// Flow: a raw or not-ready item is turned into its word directly; a force or alarm
// word waits for the bit-serial divider, and a zero divisor skips the division.
// A dividing item goes through start, 25 divider steps, sign fix and word load, then
// its result words are written out one by one. The back end takes no new job before
// it is through with the last one; items that give no job stop in the front end.
// Reset: arst_n clears configuration, alarm state, last emit time and queues.
// ----------------------------------------------------------------------------
// load_cell_force_alarm
// Load-cell force publisher with a symmetric threshold alarm.
// ----------------------------------------------------------------------------
module load_cell_force_alarm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcfa_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [31:0]                   time_ms,
	input  logic signed [23:0]            sample,
	input  logic                          sample_ready,
	output logic                          empty,
	input  logic                          pop,
	output logic [2:0]                    kind,
	output logic signed [31:0]            value,
	output logic                          last
);
	import lcfa_pkg::*;

	cfg_t     cfg;
	job_t     job_in;
	job_t     job_out;
	logic     job_push;
	logic     jobq_full;
	logic     job_valid;
	logic     job_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	lcfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcfa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.time_ms      (time_ms),
		.sample       (sample),
		.sample_ready (sample_ready),
		.cfg          (cfg),
		.jobq_full    (jobq_full),
		.job_push     (job_push),
		.job          (job_in)
	);

	lcfa_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.job_in  (job_in),
		.full    (jobq_full),
		.pop     (job_pop),
		.valid   (job_valid),
		.job_out (job_out)
	);

	lcfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lcfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job       (job_out),
		.job_pop   (job_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	// The front end never writes a job into a full queue.
	a_no_job_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !jobq_full)
		else $error("job written while the job queue is full");

	// The divider is only started while it is idle.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A quotient is reported for one cycle only.
	a_div_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |=> !div_rsp.done)
		else $error("divider done held for more than one cycle");

	// A job is taken only when the divider has nothing left to report.
	a_pop_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !div_rsp.busy && !div_rsp.done)
		else $error("job taken while a division is in flight");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the load-cell force alarm block. A directed part covers the
// register extremes, every request mode, the disabled block, the period check
// with time wrap and alarm entry and exit. Random traffic under several
// register settings follows, then a long receiver stall that fills the block.
// Every word popped is checked field by field against a predictor in the
// testbench.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lcfa_pkg::*;

	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         SETTLE_CYCLES = 400;
	localparam int         LIMIT_CYCLES  = 500000;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    push;
	logic                    full;
	logic [1:0]              mode;
	logic [31:0]             time_ms;
	logic signed [23:0]      sample;
	logic                    sample_ready;
	logic                    empty;
	logic                    pop;
	logic [2:0]              kind;
	logic signed [31:0]      value;
	logic                    last;

	// Shadow copy of the registers and of the block's state.
	logic                    cfg_enable;
	logic [31:0]             cfg_period;
	logic signed [15:0]      cfg_limit;
	logic signed [23:0]      cfg_offset;
	logic signed [31:0]      cfg_scale;
	logic [31:0]             last_emit;
	logic                    alarm_on;

	res_t                    expected_words[$];
	res_t                    item_words[$];
	res_t                    head_word;
	int                      mismatches;
	int                      hold_off;
	bit                      calm;
	logic [31:0]             now_ms;
	int                      cycles;

	load_cell_force_alarm dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.time_ms      (time_ms),
		.sample       (sample),
		.sample_ready (sample_ready),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.value        (value),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic res_t make_word(logic [2:0] k, longint v);
		res_t w;
		w.kind  = k;
		w.value = v[31:0];
		w.last  = 1'b0;
		return w;
	endfunction

	function automatic longint scaled_force(logic signed [23:0] raw);
		longint diff;
		diff = longint'(raw) - longint'(cfg_offset);
		if (cfg_scale == 0)
			return 0;
		return diff / longint'(cfg_scale);
	endfunction

	// The limit is compared in wide arithmetic, so a negative limit trips on any force.
	function automatic void step_alarm(longint f);
		longint lim;
		bit     over;
		lim  = longint'(cfg_limit);
		over = (f > lim) || (f < -lim);
		if (over && !alarm_on) begin
			alarm_on = 1'b1;
			item_words.push_back(make_word(KIND_ALARM, 0));
			item_words.push_back(make_word(KIND_ALARM_VAL, f));
		end else if (!over && alarm_on) begin
			alarm_on = 1'b0;
			item_words.push_back(make_word(KIND_NORMAL, 0));
			item_words.push_back(make_word(KIND_ALARM_VAL, 0));
		end
	endfunction

	function automatic void predict_words(logic [1:0] m, logic [31:0] t,
			logic signed [23:0] s, logic r);
		logic [31:0] elapsed;
		longint      f;
		item_words.delete();
		if (m == MODE_POLL) begin
			if (!cfg_enable)
				return;
			if (cfg_period == 0) begin
				if (r)
					step_alarm(scaled_force(s));
			end else begin
				elapsed = t - last_emit;
				if (elapsed < cfg_period)
					return;
				last_emit = t;
				if (!r)
					return;
				f = scaled_force(s);
				item_words.push_back(make_word(KIND_FORCE, f));
				step_alarm(f);
			end
		end else if (!r) begin
			item_words.push_back(make_word(KIND_NOT_READY, 0));
		end else if (m == MODE_RAW) begin
			item_words.push_back(make_word(KIND_RAW, longint'(s)));
		end else begin
			item_words.push_back(make_word(KIND_FORCE, scaled_force(s)));
		end
		if (item_words.size() > 0)
			item_words[item_words.size() - 1].last = 1'b1;
		foreach (item_words[i])
			expected_words.push_back(item_words[i]);
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ENABLE: cfg_enable = data[0];
			REG_PERIOD: cfg_period = data;
			REG_LIMIT:  cfg_limit  = data[15:0];
			REG_OFFSET: cfg_offset = data[23:0];
			REG_SCALE:  cfg_scale  = data;
			default: ;
		endcase
	endtask

	// Leaves push high so that back-to-back words need no second assignment.
	task automatic offer_item(input logic [1:0] m, input logic [31:0] t,
			input logic signed [23:0] s, input logic r);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		mode         <= m;
		time_ms      <= t;
		sample       <= s;
		sample_ready <= r;
		forever begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
			if (taken)
				break;
		end
		predict_words(m, t, s, r);
	endtask

	// Waits until every expected word has come out, then lets words that
	// cause no result work their way through before the registers change.
	task automatic settle();
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : pop_driver
		int idle_left;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				pop <= 1'b0;
				hold_off--;
			end else if (idle_left > 0) begin
				pop <= 1'b0;
				idle_left--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					idle_left = pick_gap();
			end
		end
	end

	// Outputs change only at the rising edge, so the falling edge sees the
	// word that the next rising edge takes.
	always @(negedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d value %0d last %0b", kind, value, last);
				mismatches++;
			end else begin
				head_word = expected_words.pop_front();
				if (kind !== head_word.kind) begin
					$error("kind: expected %0d, got %0d", head_word.kind, kind);
					mismatches++;
				end
				if (value !== head_word.value) begin
					$error("value: expected %0d, got %0d", head_word.value, value);
					mismatches++;
				end
				if (last !== head_word.last) begin
					$error("last: expected %0b, got %0b", head_word.last, last);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		// Disabled after reset, and a zero divisor forces a zero force.
		offer_item(MODE_POLL, 32'd100, 24'sd500, 1'b1);
		offer_item(MODE_FORCE, 32'd0, 24'h7FFFFF, 1'b1);
		offer_item(MODE_RAW, 32'hFFFFFFFF, 24'h800000, 1'b1);
		offer_item(MODE_RAW, 32'd0, 24'sd17, 1'b0);
		offer_item(MODE_SPARE, 32'd0, 24'sd5, 1'b1);
	endtask

	task automatic test_watch_alarm();
		settle();
		write_reg(REG_ENABLE, 32'd1);
		write_reg(REG_PERIOD, 32'd0);
		write_reg(REG_LIMIT, 32'd100);
		write_reg(REG_OFFSET, 32'd1000);
		write_reg(REG_SCALE, -32'sd7);
		offer_item(MODE_POLL, 32'd0, 24'sd1000, 1'b1);
		offer_item(MODE_POLL, 32'd0, 24'sd293, 1'b1);
		offer_item(MODE_POLL, 32'd0, 24'sd1707, 1'b1);
		offer_item(MODE_POLL, 32'd0, 24'sd293, 1'b0);
		offer_item(MODE_POLL, 32'd0, 24'sd300, 1'b1);
		// Negative quotients truncate toward zero.
		offer_item(MODE_FORCE, 32'd0, 24'sd1020, 1'b1);
		offer_item(MODE_SPARE, 32'd0, 24'sd980, 1'b1);
	endtask

	task automatic test_period();
		settle();
		write_reg(REG_PERIOD, 32'd10);
		offer_item(MODE_POLL, 32'd5, 24'sd1000, 1'b1);
		offer_item(MODE_POLL, 32'd10, 24'sd1000, 1'b1);
		// A poll without a sample still restarts the period.
		offer_item(MODE_POLL, 32'd25, 24'sd1000, 1'b0);
		offer_item(MODE_POLL, 32'd30, 24'sd1000, 1'b1);
		offer_item(MODE_POLL, 32'd35, -24'sd400, 1'b1);
		offer_item(MODE_POLL, 32'hFFFFFFF8, 24'sd1000, 1'b1);
		// Elapsed time across the wrap of the millisecond counter.
		offer_item(MODE_POLL, 32'd3, 24'sd1070, 1'b1);
	endtask

	task automatic test_extremes();
		settle();
		write_reg(REG_PERIOD, 32'hFFFFFFFF);
		write_reg(REG_LIMIT, 32'hFFFF8000);
		write_reg(REG_OFFSET, 32'hFF800000);
		write_reg(REG_SCALE, 32'h80000000);
		offer_item(MODE_POLL, 32'd2, 24'h7FFFFF, 1'b1);
		settle();
		write_reg(REG_LIMIT, 32'h00007FFF);
		write_reg(REG_SCALE, 32'd1);
		write_reg(REG_OFFSET, 32'h007FFFFF);
		write_reg(REG_PERIOD, 32'd0);
		offer_item(MODE_FORCE, 32'd0, 24'h800000, 1'b1);
		offer_item(MODE_POLL, 32'd0, 24'h7FFFFF, 1'b1);
		settle();
		write_reg(REG_SCALE, 32'h7FFFFFFF);
		write_reg(REG_ENABLE, 32'd0);
		offer_item(MODE_POLL, 32'd9, 24'h800000, 1'b1);
		offer_item(MODE_FORCE, 32'd0, 24'h800000, 1'b1);
		offer_item(MODE_RAW, 32'd0, 24'h7FFFFF, 1'b1);
	endtask

	task automatic randomize_config();
		int                 pick;
		int                 mag;
		logic [31:0]        per;
		logic signed [31:0] scl;
		logic signed [31:0] lim;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			per = 32'd0;
		else if (pick == 3)
			per = $urandom_range(200, 1000);
		else
			per = $urandom_range(1, 40);
		pick = $urandom_range(0, 9);
		mag  = $urandom_range(1, 500);
		if (pick == 0)
			scl = 0;
		else if (pick == 1)
			scl = $urandom;
		else
			scl = ($urandom_range(0, 1) == 1) ? -mag : mag;
		pick = $urandom_range(0, 9);
		mag  = $urandom_range(1, 32768);
		if (pick == 0)
			lim = -mag;
		else if (pick == 1)
			lim = 32767;
		else
			lim = $urandom_range(0, 2000);
		write_reg(REG_ENABLE, {31'd0, $urandom_range(0, 7) != 0});
		write_reg(REG_PERIOD, per);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_OFFSET, $urandom);
		write_reg(REG_SCALE, scl);
	endtask

	// Half of the samples land near the alarm threshold and three in ten near half of it, so that the alarm toggles.
	function automatic logic signed [23:0] pick_sample();
		longint target;
		longint raw;
		int     jitter;
		int     choice;
		choice = $urandom_range(0, 9);
		if (choice < 2 || cfg_scale == 0)
			return 24'($urandom);
		jitter = $urandom_range(0, 6);
		target = longint'(cfg_limit) + jitter - 3;
		if (choice < 5)
			target = target / 2;
		if ($urandom_range(0, 1) == 1)
			target = -target;
		jitter = $urandom_range(0, 3);
		raw = longint'(cfg_offset) + target * longint'(cfg_scale) + jitter;
		if (raw < -8388608 || raw > 8388607)
			return 24'($urandom);
		return raw[23:0];
	endfunction

	task automatic offer_random_item();
		int          pick;
		int          step_max;
		logic [1:0]  m;
		logic [31:0] step;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			m = MODE_POLL;
		else if (pick < 8)
			m = MODE_FORCE;
		else if (pick < 9)
			m = MODE_RAW;
		else
			m = MODE_SPARE;
		if ($urandom_range(0, 19) == 0) begin
			now_ms = $urandom;
		end else begin
			step_max = (cfg_period > 300) ? 300 : int'(cfg_period) + 3;
			step     = $urandom_range(0, step_max);
			now_ms   = now_ms + step;
		end
		offer_item(m, now_ms, pick_sample(), $urandom_range(0, 7) != 0);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			randomize_config();
			// One phase runs with no idling on either side.
			calm = (phase == 2);
			repeat (47) offer_random_item();
		end
		calm = 1'b0;
	endtask

	task automatic test_back_pressure();
		settle();
		write_reg(REG_ENABLE, 32'd1);
		hold_off = 500;
		calm     = 1'b1;
		repeat (50)
			offer_item(($urandom_range(0, 1) == 1) ? MODE_RAW : MODE_FORCE, now_ms,
				24'($urandom), 1'b1);
		calm = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		push         = 1'b0;
		pop          = 1'b0;
		mode         = MODE_POLL;
		time_ms      = '0;
		sample       = '0;
		sample_ready = 1'b0;
		cfg_enable   = 1'b0;
		cfg_period   = '0;
		cfg_limit    = '0;
		cfg_offset   = '0;
		cfg_scale    = '0;
		last_emit    = '0;
		alarm_on     = 1'b0;
		mismatches   = 0;
		hold_off     = 0;
		calm         = 1'b0;
		now_ms       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_watch_alarm();
		test_period();
		test_extremes();
		test_random_traffic();
		test_back_pressure();
		settle();

		if (mismatches == 0 && expected_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
